[rtl/glwb_pkg.sv]
package glwb_pkg;

	// Column counter capacity and the last column that it may reach.
	localparam int unsigned MAX_COLUMNS = 65536;
	localparam logic [15:0] COL_LIMIT = (MAX_COLUMNS < 65535) ?
		16'(MAX_COLUMNS - 1) : 16'd65534;

	// Saturation limits of run widths and of the padding.
	localparam logic [21:0] WIDTH_MAX = 22'h3FFFFF;
	localparam logic [19:0] PAD_MAX   = 20'hFFFFF;

	// Configuration register indexes.
	localparam logic [2:0] REG_MAX_WIDTH   = 3'd0;
	localparam logic [2:0] REG_WRAP_MODE   = 3'd1;
	localparam logic [2:0] REG_KEEP_INDENT = 3'd2;
	localparam logic [2:0] REG_TAB_WIDTH   = 3'd3;
	localparam logic [2:0] REG_SPACE_WIDTH = 3'd4;
	localparam logic [2:0] REG_MONOSPACE   = 3'd5;

	// Wrap modes.
	localparam logic [1:0] MODE_NONE   = 2'd0;
	localparam logic [1:0] MODE_LETTER = 2'd1;
	localparam logic [1:0] MODE_WORD   = 2'd2;

	// Character codes that the classifier looks for.
	localparam logic [20:0] CH_TAB    = 21'h09;
	localparam logic [20:0] CH_LF     = 21'h0A;
	localparam logic [20:0] CH_VT     = 21'h0B;
	localparam logic [20:0] CH_FF     = 21'h0C;
	localparam logic [20:0] CH_CR     = 21'h0D;
	localparam logic [20:0] CH_SPACE  = 21'h20;
	localparam logic [20:0] CH_COMMA  = 21'h2C;
	localparam logic [20:0] CH_HYPHEN = 21'h2D;
	localparam logic [20:0] CH_PERIOD = 21'h2E;

	typedef struct packed {
		logic [19:0] max_width;
		logic [1:0]  wrap_mode;
		logic        keep_indent;
		logic [5:0]  tab_width;
		logic [13:0] space_width;
		logic        monospace;
	} cfg_t;

	// A classified character as it travels from the front to the back.
	typedef struct packed {
		logic        is_ws;
		logic        is_sep;
		logic [19:0] advance;
		logic        eol;
	} item_t;

	function automatic logic [21:0] sat_add(logic [21:0] a, logic [21:0] b);
		logic [22:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[22] ? WIDTH_MAX : s[21:0];
	endfunction

endpackage

[rtl/glwb_in_if.sv]
interface glwb_in_if;
	logic        valid;
	logic        ready;
	logic [20:0] char_code;
	logic [15:0] glyph_advance;
	logic        end_of_line;

	modport source (output valid, output char_code, output glyph_advance,
		output end_of_line, input ready);
	modport sink (input valid, input char_code, input glyph_advance,
		input end_of_line, output ready);
endinterface

[rtl/glwb_out_if.sv]
interface glwb_out_if;
	logic        valid;
	logic        ready;
	logic        is_break;
	logic [15:0] break_column;
	logic        line_done;
	logic [19:0] indent_padding;

	modport source (output valid, output is_break, output break_column,
		output line_done, output indent_padding, input ready);
	modport sink (input valid, input is_break, input break_column,
		input line_done, input indent_padding, output ready);
endinterface

[rtl/glwb_front.sv]
module glwb_front
	import glwb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	glwb_in_if.sink   chars,
	output logic      push,
	output item_t     push_item,
	input  logic      full
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_d;
	logic  is_tab;
	logic  take;

	// Classify the character and work out its advance.
	always_comb begin
		is_tab = (chars.char_code == CH_TAB);
		item_d.is_ws = (chars.char_code == CH_SPACE) || is_tab ||
			(chars.char_code == CH_LF) || (chars.char_code == CH_VT) ||
			(chars.char_code == CH_FF) || (chars.char_code == CH_CR);
		item_d.is_sep = (chars.char_code == CH_SPACE) || (chars.char_code == CH_PERIOD) ||
			(chars.char_code == CH_HYPHEN) || (chars.char_code == CH_COMMA);
		if (is_tab) begin
			item_d.advance = cfg.space_width * cfg.tab_width;
		end else if (cfg.monospace) begin
			item_d.advance = {6'd0, cfg.space_width};
		end else begin
			item_d.advance = {4'd0, chars.glyph_advance};
		end
		item_d.eol = chars.end_of_line;
	end

	// The stage register frees up whenever its item moves into the queue.
	assign push        = valid_s1 && !full;
	assign chars.ready = !valid_s1 || !full;
	assign take        = chars.valid && chars.ready;
	assign push_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

endmodule

[rtl/glwb_fifo.sv]
module glwb_fifo
	import glwb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t pop_item,
	output logic  empty
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_item = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/glwb_back.sv]
module glwb_back
	import glwb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  item_t     item,
	input  logic      empty,
	output logic      pop,
	glwb_out_if.source breaks
);

	// Line state.
	logic [21:0] run_width_q;
	logic [15:0] column_q;
	logic [15:0] last_sep_column_q;
	logic [21:0] width_at_sep_q;
	logic        in_indent_q;
	logic [21:0] indent_width_q;
	logic [19:0] padding_q;
	logic        broke_in_indent_q;

	// Output register.
	logic        out_valid_q;
	logic        is_break_q;
	logic [15:0] break_column_q;
	logic        line_done_q;
	logic [19:0] indent_padding_q;

	logic        wrap;
	logic [19:0] space20;
	logic [19:0] big;
	logic [19:0] cap;
	logic [21:0] pad_cand;
	logic [21:0] run0;
	logic [21:0] run1;
	logic [21:0] rest;
	logic [21:0] pad_now;
	logic [21:0] run_n;
	logic [15:0] column_n;
	logic [15:0] last_sep_n;
	logic [21:0] width_at_sep_n;
	logic        in_indent_n;
	logic [21:0] indent_width_n;
	logic [19:0] padding_n;
	logic        broke_n;
	logic        brk;
	logic [15:0] bcol;

	assign pop = !empty && (!out_valid_q || breaks.ready);

	// Indent cap and the padding it allows.
	always_comb begin
		wrap     = (cfg.wrap_mode == MODE_LETTER) || (cfg.wrap_mode == MODE_WORD);
		space20  = {6'd0, cfg.space_width};
		big      = (cfg.max_width > space20) ? (cfg.max_width - space20) : 20'd0;
		cap      = (big > space20) ? big : space20;
		pad_cand = ((cap != 20'd0) && (indent_width_q > {2'd0, cap})) ? 22'd0 :
			indent_width_q;
	end

	// Next line state and the result of the current character.
	always_comb begin
		run0           = run_width_q;
		in_indent_n    = in_indent_q;
		indent_width_n = indent_width_q;
		padding_n      = padding_q;
		broke_n        = broke_in_indent_q;
		last_sep_n     = last_sep_column_q;
		width_at_sep_n = width_at_sep_q;
		brk            = 1'b0;
		bcol           = 16'd0;
		run1           = 22'd0;
		rest           = 22'd0;

		if (in_indent_q) begin
			if (item.is_ws) begin
				indent_width_n = sat_add(indent_width_q, {2'd0, item.advance});
			end else begin
				in_indent_n = 1'b0;
				if (wrap && cfg.keep_indent) begin
					padding_n = (pad_cand > {2'd0, PAD_MAX}) ? PAD_MAX : pad_cand[19:0];
					if (broke_in_indent_q) begin
						run0 = sat_add(run_width_q, {2'd0, padding_n});
					end
				end
			end
		end
		pad_now = in_indent_n ? 22'd0 : {2'd0, padding_n};
		run_n   = run0;

		if (wrap) begin
			run1  = sat_add(run0, {2'd0, item.advance});
			run_n = run1;
			if (run1 > {2'd0, cfg.max_width}) begin
				brk = 1'b1;
				if ((cfg.wrap_mode == MODE_WORD) && (last_sep_column_q != 16'd0)) begin
					rest  = (run1 >= width_at_sep_q) ? (run1 - width_at_sep_q) : 22'd0;
					bcol  = last_sep_column_q;
					run_n = sat_add(pad_now, rest);
				end else begin
					bcol  = column_q;
					run_n = sat_add({2'd0, item.advance}, pad_now);
				end
				last_sep_n = 16'd0;
				if (in_indent_n) begin
					broke_n = 1'b1;
				end
			end else if (item.is_sep) begin
				last_sep_n     = column_q + 16'd1;
				width_at_sep_n = run1;
			end
		end

		column_n = (column_q < COL_LIMIT) ? (column_q + 16'd1) : column_q;
	end

	// Line state update; the end of a line returns everything to its start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_width_q       <= 22'd0;
			column_q          <= 16'd0;
			last_sep_column_q <= 16'd0;
			width_at_sep_q    <= 22'd0;
			in_indent_q       <= 1'b1;
			indent_width_q    <= 22'd0;
			padding_q         <= 20'd0;
			broke_in_indent_q <= 1'b0;
		end else if (pop) begin
			if (item.eol) begin
				run_width_q       <= 22'd0;
				column_q          <= 16'd0;
				last_sep_column_q <= 16'd0;
				width_at_sep_q    <= 22'd0;
				in_indent_q       <= 1'b1;
				indent_width_q    <= 22'd0;
				padding_q         <= 20'd0;
				broke_in_indent_q <= 1'b0;
			end else begin
				run_width_q       <= run_n;
				column_q          <= column_n;
				last_sep_column_q <= last_sep_n;
				width_at_sep_q    <= width_at_sep_n;
				in_indent_q       <= in_indent_n;
				indent_width_q    <= indent_width_n;
				padding_q         <= padding_n;
				broke_in_indent_q <= broke_n;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (breaks.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			is_break_q       <= brk;
			break_column_q   <= bcol;
			line_done_q      <= item.eol;
			indent_padding_q <= item.eol ? padding_n : 20'd0;
		end
	end

	assign breaks.valid          = out_valid_q;
	assign breaks.is_break       = is_break_q;
	assign breaks.break_column   = break_column_q;
	assign breaks.line_done      = line_done_q;
	assign breaks.indent_padding = indent_padding_q;

	// A column is reported only with a break.
	a_col_only_on_break: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !is_break_q |-> break_column_q == 16'd0)
		else $error("break column without a break");

	// Padding is reported only at the end of a line.
	a_pad_only_at_eol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !line_done_q |-> indent_padding_q == 20'd0)
		else $error("indent padding before the line end");

	// The line state starts over after the last character of a line.
	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop && item.eol |=> in_indent_q && (run_width_q == 22'd0) &&
		(column_q == 16'd0) && (last_sep_column_q == 16'd0))
		else $error("line state not cleared at line end");

	// Without wrapping no break is ever reported.
	a_no_break_unwrapped: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !wrap |=> !is_break_q)
		else $error("break reported with wrapping off");

endmodule

[rtl/greedy_line_wrap_breaker.sv]
// Channel   Direction  Payload
// chars     in         char_code[21], glyph_advance[16], end_of_line[1]
// breaks    out        is_break[1], break_column[16], line_done[1], indent_padding[20]
// cfg_*     in         write enable, register index[3], write data[20]
//
// One character is taken every cycle while breaks is not stalled, and yields one result;
// it passes the front stage register, the two-entry queue and the back output register.
// The per-character add and compare of the run width in the back part sets the rate.
// arst_n clears the line state, the queue and the valid flags, and loads the
// register reset values.
// A stalled breaks channel holds its result while the queue and front stage keep
// taking up to three more characters before chars.ready drops.
module greedy_line_wrap_breaker
	import glwb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	glwb_in_if.sink     chars,
	glwb_out_if.source  breaks,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	cfg_t  cfg_q;
	logic  push;
	item_t push_item;
	logic  full;
	logic  pop;
	item_t pop_item;
	logic  empty;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_width   <= 20'd65536;
			cfg_q.wrap_mode   <= MODE_NONE;
			cfg_q.keep_indent <= 1'b0;
			cfg_q.tab_width   <= 6'd4;
			cfg_q.space_width <= 14'd512;
			cfg_q.monospace   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_WIDTH:   cfg_q.max_width   <= cfg_data;
				REG_WRAP_MODE:   cfg_q.wrap_mode   <= cfg_data[1:0];
				REG_KEEP_INDENT: cfg_q.keep_indent <= cfg_data[0];
				REG_TAB_WIDTH:   cfg_q.tab_width   <= cfg_data[5:0];
				REG_SPACE_WIDTH: cfg_q.space_width <= cfg_data[13:0];
				REG_MONOSPACE:   cfg_q.monospace   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	glwb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.chars     (chars),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	glwb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	glwb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (pop_item),
		.empty  (empty),
		.pop    (pop),
		.breaks (breaks)
	);

endmodule
